[design/lwts_pkg.sv]
// ----------------------------------------------------------------------------
// lwts_pkg: shared types and constants of the load weighted torque split
// Field widths, pipeline widths, register codes, the word types of the
// item and limit channels and the divider lane types.
// ----------------------------------------------------------------------------
`default_nettype none

package lwts_pkg;

    // Field widths of the channel words
    localparam int IN_W       = 16;
    localparam int LIM_W      = 20;
    localparam int RPM_W      = 15;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Fractional widths actually used inside the input fields
    localparam int PEDAL_BITS = 16;
    localparam int LOAD_BITS  = 16;

    localparam int NUM_WHEELS = 4;
    localparam int MAXT_W     = 16;
    // Axle weight in Q2.14, up to and including 2.0
    localparam int W_W        = 16;

    // Datapath widths
    localparam int A_W     = PEDAL_BITS + MAXT_W;      // request times max torque
    localparam int A_LO_W  = 16;
    localparam int A_HI_W  = A_W - A_LO_W;
    localparam int B_W     = W_W + LOAD_BITS;          // weight times load
    localparam int PH_W    = A_HI_W + B_W;
    localparam int PL_W    = A_LO_W + B_W;
    localparam int P_W     = A_W + B_W;
    // Pool factor of four folded in: drop PEDAL_BITS + 14 - 2 bits
    localparam int SHIFT   = PEDAL_BITS + 12;
    // Weight never exceeds 2^15, so the product stays below 2^(P_W-1)
    localparam int T_W     = P_W - 1 - SHIFT;
    // Share is at most the whole pool, below 2^(MAXT_W+3); one spare bit
    localparam int QUO_W   = MAXT_W + 4;
    localparam int DIV_W   = LOAD_BITS + 2;

    localparam logic [W_W-1:0]   TWO_Q14   = W_W'(32768);
    localparam logic [RPM_W-1:0] DRIVE_RPM = RPM_W'(20000);
    // Per-axle regen divides by four to undo the pool factor
    localparam logic [DIV_W-1:0] DIV_AXLE  = DIV_W'(4);

    localparam logic [QUO_W-1:0] LIM_POS_MAX = QUO_W'((1 << (LIM_W - 1)) - 1);
    localparam logic [QUO_W-1:0] LIM_NEG_MAG = QUO_W'(1 << (LIM_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DRIVE   = 2'd0,
        REG_MAX_BRAKE   = 2'd1,
        REG_REAR_SPLIT  = 2'd2,
        REG_REGEN_VECT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [IN_W-1:0] accel_pedal;
        logic [IN_W-1:0] brake_pedal;
        logic [IN_W-1:0] load_front_left;
        logic [IN_W-1:0] load_front_right;
        logic [IN_W-1:0] load_rear_left;
        logic [IN_W-1:0] load_rear_right;
    } lwts_item_t;

    typedef struct packed {
        logic signed [LIM_W-1:0] limit_front_left;
        logic signed [LIM_W-1:0] limit_front_right;
        logic signed [LIM_W-1:0] limit_rear_left;
        logic signed [LIM_W-1:0] limit_rear_right;
        logic [RPM_W-1:0]        target_rpm;
        logic                    zero_load_flag;
    } lwts_limit_t;

    // Side band that travels with each word through the divider
    typedef struct packed {
        logic drive;
        logic zflag;
    } lwts_ctl_t;

    // One divider lane: partial remainder and dividend bits / quotient bits
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] dq;
    } div_lane_t;

    typedef div_lane_t [NUM_WHEELS-1:0]        div_vec_t;
    typedef logic [NUM_WHEELS-1:0][QUO_W-1:0]  quo_vec_t;

endpackage

`default_nettype wire

[design/lwts_item_if.sv]
// ----------------------------------------------------------------------------
// lwts_item_if: pedal and load-cell word channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwts_item_if
    import lwts_pkg::*;
();
    logic       valid;
    logic       ready;
    lwts_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/lwts_limit_if.sv]
// ----------------------------------------------------------------------------
// lwts_limit_if: torque limit word channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwts_limit_if
    import lwts_pkg::*;
();
    logic        valid;
    logic        ready;
    lwts_limit_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/lwts_cfg_if.sv]
// ----------------------------------------------------------------------------
// lwts_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lwts_cfg_if
    import lwts_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/load_weighted_torque_split.sv]
// ----------------------------------------------------------------------------
// load_weighted_torque_split: per-wheel torque limits from pedals and loads
// Pipelined four-wheel split of a signed pedal request by weight and load.
// ----------------------------------------------------------------------------
// Usage
//   item   : sink of pedal and load-cell words, taken when valid and ready.
//   limits : source of result words, one per input word, in order.
//   cfg    : register writes (max drive, max brake, rear split, regen
//            vectoring); always ready, write only while the block is idle.
// Timing
//   One word enters per cycle while limits is not stalled. A word passes 25
//   register stages: input, multiply, partial products, product sum, one
//   stage per quotient bit of the 20-bit divider, and the output register.
// Stall
//   The whole pipeline advances together. While a result word waits for
//   limits.ready every stage holds, and item.ready drops; nothing is lost or
//   repeated. Bubbles do not stall the front end.
// Reset
//   rst_n clears all valid bits and loads the register reset values
//   (max torques 0, rear split 1.0, regen vectoring off).
// ----------------------------------------------------------------------------
`default_nettype none

module load_weighted_torque_split
    import lwts_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    lwts_item_if.sink    item,
    lwts_limit_if.source limits,
    lwts_cfg_if.sink     cfg
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MAXT_W-1:0] max_drive_reg;
    logic [MAXT_W-1:0] max_brake_reg;
    logic [W_W-1:0]    rear_split_reg;
    logic              regen_vect_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_drive_reg  <= '0;
            max_brake_reg  <= '0;
            rear_split_reg <= W_W'(16384);
            regen_vect_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_DRIVE:  max_drive_reg  <= cfg.data[MAXT_W-1:0];
                REG_MAX_BRAKE:  max_brake_reg  <= cfg.data[MAXT_W-1:0];
                REG_REAR_SPLIT: rear_split_reg <= cfg.data[W_W-1:0];
                REG_REGEN_VECT: regen_vect_reg <= cfg.data[0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: advance whenever the output register is free
    // ------------------------------------------------------------------
    logic        en;
    logic        out_valid_reg;
    lwts_limit_t out_reg;

    assign en          = !out_valid_reg || limits.ready;
    assign item.ready  = en;

    // ------------------------------------------------------------------
    // Stage 1: request magnitude and direction, loads
    // ------------------------------------------------------------------
    logic [PEDAL_BITS-1:0] accel;
    logic [PEDAL_BITS-1:0] brake;
    logic                  drive_next;
    logic [PEDAL_BITS-1:0] req_next;
    logic [LOAD_BITS-1:0]  load_next [NUM_WHEELS];

    logic                  valid1_reg;
    logic                  drive1_reg;
    logic [PEDAL_BITS-1:0] req1_reg;
    logic [LOAD_BITS-1:0]  load1_reg [NUM_WHEELS];

    always_comb
    begin
        accel        = item.data.accel_pedal[PEDAL_BITS-1:0];
        brake        = item.data.brake_pedal[PEDAL_BITS-1:0];
        // Equal pedals count as drive with a zero request
        drive_next   = accel >= brake;
        req_next     = drive_next ? accel - brake : brake - accel;
        load_next[0] = item.data.load_front_left[LOAD_BITS-1:0];
        load_next[1] = item.data.load_front_right[LOAD_BITS-1:0];
        load_next[2] = item.data.load_rear_left[LOAD_BITS-1:0];
        load_next[3] = item.data.load_rear_right[LOAD_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 2: request times max torque, weight times load, load sum
    // ------------------------------------------------------------------
    logic [MAXT_W-1:0] maxt;
    logic [W_W-1:0]    rs;
    logic [W_W-1:0]    weight [NUM_WHEELS];
    logic              lw_mode;
    logic [DIV_W-1:0]  sum;
    logic [A_W-1:0]    a_next;
    logic [B_W-1:0]    b_next [NUM_WHEELS];
    logic [DIV_W-1:0]  dsr_next;
    lwts_ctl_t         ctl_next;

    logic              valid2_reg;
    lwts_ctl_t         ctl2_reg;
    logic [DIV_W-1:0]  dsr2_reg;
    logic [A_W-1:0]    a2_reg;
    logic [B_W-1:0]    b2_reg [NUM_WHEELS];

    always_comb
    begin
        maxt      = drive1_reg ? max_drive_reg : max_brake_reg;
        // Clamp the rear weight at 2.0 so the front weight never goes negative
        rs        = (rear_split_reg > TWO_Q14) ? TWO_Q14 : rear_split_reg;
        weight[0] = TWO_Q14 - rs;
        weight[1] = TWO_Q14 - rs;
        weight[2] = rs;
        weight[3] = rs;
        lw_mode   = drive1_reg || regen_vect_reg;
        sum       = DIV_W'(load1_reg[0]) + DIV_W'(load1_reg[1])
                  + DIV_W'(load1_reg[2]) + DIV_W'(load1_reg[3]);
        a_next    = A_W'(req1_reg) * A_W'(maxt);
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            // Per-axle regen ignores the loads: the weight alone enters
            b_next[w] = lw_mode ? B_W'(weight[w]) * B_W'(load1_reg[w])
                                : B_W'(weight[w]);
        end
        ctl_next.drive = drive1_reg;
        ctl_next.zflag = lw_mode && (sum == '0);
        // Zero load sum: divide by one, the limits are forced to zero later
        if (ctl_next.zflag)
        begin
            dsr_next = DIV_W'(1);
        end
        else if (lw_mode)
        begin
            dsr_next = sum;
        end
        else
        begin
            dsr_next = DIV_AXLE;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: split the wide product into two partial products per wheel
    // ------------------------------------------------------------------
    logic [PH_W-1:0] ph_next [NUM_WHEELS];
    logic [PL_W-1:0] pl_next [NUM_WHEELS];

    logic            valid3_reg;
    lwts_ctl_t       ctl3_reg;
    logic [DIV_W-1:0] dsr3_reg;
    logic [PH_W-1:0] ph3_reg [NUM_WHEELS];
    logic [PL_W-1:0] pl3_reg [NUM_WHEELS];

    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            ph_next[w] = PH_W'(a2_reg[A_W-1:A_LO_W]) * PH_W'(b2_reg[w]);
            pl_next[w] = PL_W'(a2_reg[A_LO_W-1:0]) * PL_W'(b2_reg[w]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: add partial products, scale down, load divider lanes
    // ------------------------------------------------------------------
    logic [P_W-1:0] prod [NUM_WHEELS];
    div_vec_t       lanes_next;

    logic             valid4_reg;
    lwts_ctl_t        ctl4_reg;
    logic [DIV_W-1:0] dsr4_reg;
    div_vec_t         lanes4_reg;

    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            prod[w] = (P_W'(ph3_reg[w]) << A_LO_W) + P_W'(pl3_reg[w]);
            // Top bits are below the divisor, so they seed the remainder
            lanes_next[w].rem = DIV_W'(prod[w][SHIFT+T_W-1:SHIFT+QUO_W]);
            lanes_next[w].dq  = prod[w][SHIFT+QUO_W-1:SHIFT];
        end
    end

    // ------------------------------------------------------------------
    // Front end registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= item.valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drive1_reg <= drive_next;
            req1_reg   <= req_next;
            ctl2_reg   <= ctl_next;
            dsr2_reg   <= dsr_next;
            a2_reg     <= a_next;
            ctl3_reg   <= ctl2_reg;
            dsr3_reg   <= dsr2_reg;
            ctl4_reg   <= ctl3_reg;
            dsr4_reg   <= dsr3_reg;
            lanes4_reg <= lanes_next;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                load1_reg[w] <= load_next[w];
                b2_reg[w]    <= b_next[w];
                ph3_reg[w]   <= ph_next[w];
                pl3_reg[w]   <= pl_next[w];
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, four wheels side by side
    // ------------------------------------------------------------------
    logic      div_valid;
    lwts_ctl_t div_ctl;
    quo_vec_t  div_quo;

    lwts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid4_reg),
        .in_ctl    (ctl4_reg),
        .in_dsr    (dsr4_reg),
        .in_lanes  (lanes4_reg),
        .out_valid (div_valid),
        .out_ctl   (div_ctl),
        .out_quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Output stage: sign, saturate, zero-load override
    // ------------------------------------------------------------------
    logic [LIM_W-1:0] lim [NUM_WHEELS];
    lwts_limit_t      out_next;

    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            if (div_ctl.zflag)
            begin
                lim[w] = '0;
            end
            else if (!div_ctl.drive)
            begin
                // Regen: negate the magnitude, rounding toward zero
                lim[w] = (div_quo[w] > LIM_NEG_MAG) ? LIM_W'(-LIM_NEG_MAG)
                                                     : LIM_W'(-div_quo[w]);
            end
            else
            begin
                lim[w] = (div_quo[w] > LIM_POS_MAX) ? LIM_W'(LIM_POS_MAX)
                                                     : LIM_W'(div_quo[w]);
            end
        end
        out_next.limit_front_left  = lim[0];
        out_next.limit_front_right = lim[1];
        out_next.limit_rear_left   = lim[2];
        out_next.limit_rear_right  = lim[3];
        out_next.target_rpm        = div_ctl.drive ? DRIVE_RPM : '0;
        out_next.zero_load_flag    = div_ctl.zflag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign limits.valid = out_valid_reg;
    assign limits.data  = out_reg;

endmodule

`default_nettype wire

[design/lwts_div.sv]
// ----------------------------------------------------------------------------
// lwts_div: four-lane pipelined restoring divider
// One quotient bit per stage, QUO_W stages, shared divisor per word.
// ----------------------------------------------------------------------------
`default_nettype none

module lwts_div
    import lwts_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire lwts_ctl_t        in_ctl,
    input  wire logic [DIV_W-1:0] in_dsr,
    input  wire div_vec_t         in_lanes,
    output logic                  out_valid,
    output lwts_ctl_t             out_ctl,
    output quo_vec_t              out_quo
);

    div_vec_t         lane_reg  [QUO_W];
    div_vec_t         lane_next [QUO_W];
    div_vec_t         src_lane  [QUO_W];
    logic [DIV_W-1:0] dsr_reg   [QUO_W];
    logic [DIV_W-1:0] src_dsr   [QUO_W];
    lwts_ctl_t        ctl_reg   [QUO_W];
    lwts_ctl_t        src_ctl   [QUO_W];
    logic [QUO_W-1:0] valid_reg;

    // Shift in the next dividend bit, subtract where it fits
    function automatic div_lane_t div_step(div_lane_t x, logic [DIV_W-1:0] d);
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        div_lane_t      y;
        trial = {x.rem, x.dq[QUO_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
        begin
            y.rem = diff[DIV_W-1:0];
            y.dq  = {x.dq[QUO_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = trial[DIV_W-1:0];
            y.dq  = {x.dq[QUO_W-2:0], 1'b0};
        end
        return y;
    endfunction

    always_comb
    begin
        src_lane[0] = in_lanes;
        src_dsr[0]  = in_dsr;
        src_ctl[0]  = in_ctl;
        for (int k = 1; k < QUO_W; k++)
        begin
            src_lane[k] = lane_reg[k-1];
            src_dsr[k]  = dsr_reg[k-1];
            src_ctl[k]  = ctl_reg[k-1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                lane_next[k][w] = div_step(src_lane[k][w], src_dsr[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QUO_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < QUO_W; k++)
            begin
                lane_reg[k] <= lane_next[k];
                dsr_reg[k]  <= src_dsr[k];
                ctl_reg[k]  <= src_ctl[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_ctl   = ctl_reg[QUO_W-1];

    always_comb
    begin
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            out_quo[w] = lane_reg[QUO_W-1][w].dq;
        end
    end

endmodule

`default_nettype wire
